FILE: rtl/core/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared types and constants of the swept box collision time block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbct_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumAxes     = 3;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned SizeW       = 31;
  localparam int unsigned PosW        = 32;
  // slab distances need 34 bits signed; magnitude fits 33 bits
  localparam int unsigned DistW       = 34;
  localparam int unsigned DistMagW    = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_SIZE_X = 2'd0,
    CFG_TARGET_SIZE_Y = 2'd1,
    CFG_TARGET_SIZE_Z = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [31:0] moving_pos_x;
    logic signed [31:0] moving_pos_y;
    logic signed [31:0] moving_pos_z;
    logic [30:0]        moving_size_x;
    logic [30:0]        moving_size_y;
    logic [30:0]        moving_size_z;
    logic signed [31:0] target_pos_x;
    logic signed [31:0] target_pos_y;
    logic signed [31:0] target_pos_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
  } in_t;

  typedef struct packed {
    logic               result_valid;
    logic               hit;
    logic signed [31:0] enter_time;
    logic signed [31:0] exit_time;
    logic [1:0]         enter_axis;
    logic               enter_negative;
    logic [1:0]         exit_axis;
    logic               exit_negative;
  } out_t;

  // per-item control that rides alongside the dividers
  typedef struct packed {
    logic       ok;
    logic [2:0] moving;
    logic [2:0] mv_pos;
    logic [2:0] mv_neg;
    logic [2:0] neg_in;
    logic [2:0] neg_out;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/swept_box_collision_time.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time
// Swept box slab test: per-axis entry/exit times, latest entry, earliest exit.
// ----------------------------------------------------------------------------
// Throughput one item per cycle while the output is not stalled. The six
// pipelined dividers (FRAC_BITS + 33 stages each) set the depth.
// The whole pipeline holds while a result waits under stall.
// Reset clears all valid bits and loads unit target sizes.
`default_nettype none

module swept_box_collision_time #(
  parameter int unsigned FRAC_BITS = sbct_pkg::FracBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire sbct_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output sbct_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [sbct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [sbct_pkg::SizeW-1:0]       cfg_wdata_i
);

  localparam int unsigned NW    = sbct_pkg::DistMagW + FRAC_BITS;
  localparam int unsigned TW    = NW + 1;
  localparam int unsigned SbD   = NW + 4;
  localparam int unsigned VldD  = NW + 7;
  localparam logic [sbct_pkg::SizeW-1:0] SizeRst = sbct_pkg::SizeW'(1 << FRAC_BITS);
  localparam logic signed [TW-1:0] TMax = TW'(64'sh7FFF_FFFF);
  localparam logic signed [TW-1:0] TMin = -TW'(64'sh8000_0000);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- configuration ----------------
  logic [sbct_pkg::SizeW-1:0] tsize_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) tsize_q[a] <= SizeRst;
    end else if (cfg_we_i) begin
      case (sbct_pkg::cfg_idx_e'(cfg_idx_i))
        sbct_pkg::CFG_TARGET_SIZE_X: tsize_q[0] <= cfg_wdata_i;
        sbct_pkg::CFG_TARGET_SIZE_Y: tsize_q[1] <= cfg_wdata_i;
        sbct_pkg::CFG_TARGET_SIZE_Z: tsize_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- valid chain ----------------
  logic [VldD-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[VldD-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[VldD-1];

  // ---------------- stage 1: input register ----------------
  sbct_pkg::in_t in_q;
  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  // ---------------- slab distances, magnitudes, signs ----------------
  logic signed [31:0]         mpos [3], tpos [3], mv [3];
  logic [30:0]                msz [3];
  logic signed [sbct_pkg::DistW-1:0] din [3], dout [3];
  logic [NW-1:0]              num1_d [3], num2_d [3];
  logic [31:0]                den_d [3];
  sbct_pkg::side_t            sb_d;
  logic                       fail;

  always_comb begin
    mpos = '{in_q.moving_pos_x, in_q.moving_pos_y, in_q.moving_pos_z};
    tpos = '{in_q.target_pos_x, in_q.target_pos_y, in_q.target_pos_z};
    mv   = '{in_q.move_x, in_q.move_y, in_q.move_z};
    msz  = '{in_q.moving_size_x, in_q.moving_size_y, in_q.moving_size_z};
    fail = 1'b0;
    sb_d = '0;
    for (int a = 0; a < 3; a++) begin
      din[a]  = {{2{tpos[a][31]}}, tpos[a]} - {{2{mpos[a][31]}}, mpos[a]}
                - {3'b000, msz[a]};
      dout[a] = {{2{tpos[a][31]}}, tpos[a]} + {3'b000, tsize_q[a]}
                - {{2{mpos[a][31]}}, mpos[a]};
      num1_d[a] = {(din[a][sbct_pkg::DistW-1]  ? 33'(-din[a])  : din[a][32:0]),
                   FRAC_BITS'(0)};
      num2_d[a] = {(dout[a][sbct_pkg::DistW-1] ? 33'(-dout[a]) : dout[a][32:0]),
                   FRAC_BITS'(0)};
      den_d[a]  = mv[a][31] ? 32'(-mv[a]) : mv[a];
      sb_d.moving[a]  = (mv[a] != 32'sd0);
      sb_d.mv_pos[a]  = !mv[a][31] && (mv[a] != 32'sd0);
      sb_d.mv_neg[a]  = mv[a][31];
      sb_d.neg_in[a]  = din[a][sbct_pkg::DistW-1] ^ mv[a][31];
      sb_d.neg_out[a] = dout[a][sbct_pkg::DistW-1] ^ mv[a][31];
      // a still axis must overlap strictly
      if (mv[a] == 32'sd0 && !(din[a] < 0 && dout[a] > 0)) fail = 1'b1;
    end
    sb_d.ok = (sb_d.moving != 3'b000) && !fail;
  end

  // ---------------- stage 2 + sideband delay line ----------------
  logic [NW-1:0]   num1_q [3], num2_q [3];
  logic [31:0]     den_q [3];
  sbct_pkg::side_t sb_q [SbD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q <= num1_d;
      num2_q <= num2_d;
      den_q  <= den_d;
      sb_q[0] <= sb_d;
      for (int k = 1; k < SbD; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // ---------------- dividers ----------------
  logic [NW-1:0] q1 [3], q2 [3];
  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbct_div #(.NW(NW), .DW(32)) u_div_in (
      .clk_i(clk_i), .en_i(en), .num_i(num1_q[a]), .den_i(den_q[a]), .quo_o(q1[a])
    );
    sbct_div #(.NW(NW), .DW(32)) u_div_out (
      .clk_i(clk_i), .en_i(en), .num_i(num2_q[a]), .den_i(den_q[a]), .quo_o(q2[a])
    );
  end

  // ---------------- stage 3: signed times; stage 4: min/max ----------------
  logic signed [TW-1:0] t1_q [3], t2_q [3], tmin_q [3], tmax_q [3];
  sbct_pkg::side_t sb_div;
  assign sb_div = sb_q[NW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        t1_q[a] <= sb_div.neg_in[a]  ? -$signed({1'b0, q1[a]}) : $signed({1'b0, q1[a]});
        t2_q[a] <= sb_div.neg_out[a] ? -$signed({1'b0, q2[a]}) : $signed({1'b0, q2[a]});
        tmin_q[a] <= (t1_q[a] < t2_q[a]) ? t1_q[a] : t2_q[a];
        tmax_q[a] <= (t1_q[a] < t2_q[a]) ? t2_q[a] : t1_q[a];
      end
    end
  end

  // ---------------- stage 5: merge x and y ----------------
  sbct_pkg::side_t sb4, sb5;
  assign sb4 = sb_q[NW+2];
  assign sb5 = sb_q[NW+3];

  logic signed [TW-1:0] e5_t_q, x5_t_q, zmin5_q, zmax5_q;
  logic [1:0]           e5_ax_q, x5_ax_q;
  logic                 e5_n_q, x5_n_q, h5_q;
  logic                 sel_e5, sel_x5;

  assign sel_e5 = !sb4.moving[0] || (sb4.moving[1] && tmin_q[1] > tmin_q[0]);
  assign sel_x5 = !sb4.moving[0] || (sb4.moving[1] && tmax_q[1] < tmax_q[0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e5_t_q  <= sel_e5 ? tmin_q[1] : tmin_q[0];
      e5_ax_q <= sel_e5 ? sbct_pkg::AXIS_Y : sbct_pkg::AXIS_X;
      e5_n_q  <= sel_e5 ? sb4.mv_pos[1] : sb4.mv_pos[0];
      x5_t_q  <= sel_x5 ? tmax_q[1] : tmax_q[0];
      x5_ax_q <= sel_x5 ? sbct_pkg::AXIS_Y : sbct_pkg::AXIS_X;
      x5_n_q  <= sel_x5 ? sb4.mv_neg[1] : sb4.mv_neg[0];
      h5_q    <= sb4.moving[0] || sb4.moving[1];
      zmin5_q <= tmin_q[2];
      zmax5_q <= tmax_q[2];
    end
  end

  // ---------------- stage 6: merge z ----------------
  logic signed [TW-1:0] e6_t_q, x6_t_q;
  logic [1:0]           e6_ax_q, x6_ax_q;
  logic                 e6_n_q, x6_n_q, ok6_q;
  logic                 sel_e6, sel_x6;

  assign sel_e6 = !h5_q || (sb5.moving[2] && zmin5_q > e5_t_q);
  assign sel_x6 = !h5_q || (sb5.moving[2] && zmax5_q < x5_t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e6_t_q  <= sel_e6 ? zmin5_q : e5_t_q;
      e6_ax_q <= sel_e6 ? sbct_pkg::AXIS_Z : e5_ax_q;
      e6_n_q  <= sel_e6 ? sb5.mv_pos[2] : e5_n_q;
      x6_t_q  <= sel_x6 ? zmax5_q : x5_t_q;
      x6_ax_q <= sel_x6 ? sbct_pkg::AXIS_Z : x5_ax_q;
      x6_n_q  <= sel_x6 ? sb5.mv_neg[2] : x5_n_q;
      ok6_q   <= sb5.ok;
    end
  end

  // ---------------- stage 7: saturate, hit, output register ----------------
  function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] s;
    s = (t > TMax) ? TMax : ((t < TMin) ? TMin : t);
    return s[31:0];
  endfunction

  sbct_pkg::out_t out_d;
  always_comb begin
    out_d = '0;
    if (ok6_q) begin
      out_d.result_valid   = 1'b1;
      out_d.hit            = (e6_t_q <= x6_t_q);
      out_d.enter_time     = sat32(e6_t_q);
      out_d.exit_time      = sat32(x6_t_q);
      out_d.enter_axis     = e6_ax_q;
      out_d.enter_negative = e6_n_q;
      out_d.exit_axis      = x6_ax_q;
      out_d.exit_negative  = x6_n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= out_d;
  end

  // ---------------- assertions ----------------
  a_hit_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.result_valid)
    else $error("hit without result");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_valid |-> out_data_o == '0)
    else $error("invalid result carries data");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.enter_axis != 2'd3 && out_data_o.exit_axis != 2'd3)
    else $error("bad axis code");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

FILE: rtl/core/sbct_div.sv
// ----------------------------------------------------------------------------
// sbct_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sbct_div #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  // the last stage only produces the quotient
  logic [NW-1:0] num_q [NW-1];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] rem_q [NW-1];
  logic [DW-1:0] den_q [NW-1];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_in, quo_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   trial;
    logic [DW-1:0] diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial[DW-1:0] - den_in;
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) quo_q[s] <= {quo_in[NW-2:0], ge};
    end

    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[s] <= {num_in[NW-2:0], 1'b0};
          rem_q[s] <= ge ? diff : trial[DW-1:0];
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

`default_nettype wire

FILE: dv/swept_box_collision_time_tb.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time_tb
// Checks the swept box slab test block against a cycle-free predictor.
// Directed boxes cover the corner cases, then random box pairs run under
// several target sizes and idle patterns. Every result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_time_tb;

  localparam int unsigned FracBits  = sbct_pkg::FracBitsDef;
  localparam int unsigned Latency   = FracBits + 40;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned RandItems = 450;  // per random phase, three phases
  localparam longint      One       = 64'sd1 << FracBits;
  localparam int unsigned Unit      = 1 << FracBits;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  sbct_pkg::in_t                  in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  sbct_pkg::out_t                 out_data_o;
  logic                           cfg_we_i;
  logic [sbct_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [sbct_pkg::SizeW-1:0]     cfg_wdata_i;

  swept_box_collision_time #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // shadow of the target extents
  logic [sbct_pkg::SizeW-1:0] target_ext [sbct_pkg::NumAxes];
  sbct_pkg::out_t             sweep_q [$];
  bit                         failed;
  int unsigned                send_idle_pct;
  int unsigned                recv_stall_pct;
  int unsigned                cycles;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic sbct_pkg::out_t sweep_time(sbct_pkg::in_t x);
    sbct_pkg::out_t r;
    longint mpos [3], msize [3], tpos [3], mv [3];
    longint din, dout, t1, t2, tmin, tmax, t_in, t_out;
    bit     have;
    r = '0;
    mpos  = '{longint'(x.moving_pos_x), longint'(x.moving_pos_y), longint'(x.moving_pos_z)};
    msize = '{longint'(x.moving_size_x), longint'(x.moving_size_y),
              longint'(x.moving_size_z)};
    tpos  = '{longint'(x.target_pos_x), longint'(x.target_pos_y), longint'(x.target_pos_z)};
    mv    = '{longint'(x.move_x), longint'(x.move_y), longint'(x.move_z)};
    have  = 1'b0;
    t_in  = 0;
    t_out = 0;
    if (mv[0] == 0 && mv[1] == 0 && mv[2] == 0) return r;
    for (int i = 0; i < 3; i++) begin
      din  = tpos[i] - (mpos[i] + msize[i]);
      dout = (tpos[i] + longint'(target_ext[i])) - mpos[i];
      if (mv[i] != 0) begin
        t1   = (din * One) / mv[i];
        t2   = (dout * One) / mv[i];
        tmin = (t1 < t2) ? t1 : t2;
        tmax = (t1 < t2) ? t2 : t1;
        if (!have || tmin > t_in) begin
          t_in             = tmin;
          r.enter_axis     = sbct_pkg::axis_e'(i);
          r.enter_negative = mv[i] > 0;
        end
        if (!have || tmax < t_out) begin
          t_out           = tmax;
          r.exit_axis     = sbct_pkg::axis_e'(i);
          r.exit_negative = mv[i] < 0;
        end
        have = 1'b1;
      end else if (!(din < 0 && dout > 0)) begin
        return '0;
      end
    end
    r.result_valid = 1'b1;
    r.hit          = t_in <= t_out;
    r.enter_time   = sat32(t_in);
    r.exit_time    = sat32(t_out);
    return r;
  endfunction

  task automatic send_box(sbct_pkg::in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    sweep_q.insert(sweep_q.size(), sweep_time(x));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sweep_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_ext(sbct_pkg::cfg_idx_e idx, logic [sbct_pkg::SizeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx != sbct_pkg::CFG_UNUSED) target_ext[idx] = val;
  endtask

  task automatic set_exts(logic [sbct_pkg::SizeW-1:0] sx, logic [sbct_pkg::SizeW-1:0] sy,
                          logic [sbct_pkg::SizeW-1:0] sz);
    drain();
    write_ext(sbct_pkg::CFG_TARGET_SIZE_X, sx);
    write_ext(sbct_pkg::CFG_TARGET_SIZE_Y, sy);
    write_ext(sbct_pkg::CFG_TARGET_SIZE_Z, sz);
    cfg_we_i <= 1'b0;
  endtask

  // mostly near boxes with modest motion so hits and misses both occur
  function automatic sbct_pkg::in_t rand_box();
    sbct_pkg::in_t x;
    logic [31:0]  mp [3], tp [3], mv [3];
    logic [30:0]  ms [3];
    int           base;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 75) begin
        base  = $urandom_range(32767) - 16384;
        mp[i] = (base <<< FracBits) + $urandom_range(65535) - 32768;
        tp[i] = mp[i] + ($urandom_range(16) - 8) * Unit + $urandom_range(65535);
        ms[i] = 31'($urandom_range(4 * Unit));
        case ($urandom_range(7))
          0:       mv[i] = '0;
          1:       mv[i] = $urandom_range(3) - 1;
          default: mv[i] = $urandom_range(16 * Unit) - 8 * Unit;
        endcase
      end else begin
        mp[i] = $urandom;
        tp[i] = $urandom;
        ms[i] = 31'($urandom);
        mv[i] = ($urandom_range(9) == 0) ? '0 : $urandom;
      end
    end
    if ($urandom_range(49) == 0) mv = '{default: '0};
    x = '{mp[0], mp[1], mp[2], ms[0], ms[1], ms[2], tp[0], tp[1], tp[2],
          mv[0], mv[1], mv[2]};
    return x;
  endfunction

  always @(posedge clk_i) begin
    sbct_pkg::out_t want;
    if (rst_ni) begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
      if (out_valid_o && !out_stall_i) begin
        if (sweep_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
          failed = 1'b1;
        end else begin
          want = sweep_q.pop_front();
          if (out_data_o.result_valid !== want.result_valid ||
              out_data_o.hit !== want.hit ||
              out_data_o.enter_time !== want.enter_time ||
              out_data_o.exit_time !== want.exit_time ||
              out_data_o.enter_axis !== want.enter_axis ||
              out_data_o.enter_negative !== want.enter_negative ||
              out_data_o.exit_axis !== want.exit_axis ||
              out_data_o.exit_negative !== want.exit_negative) begin
            $display("%0t mismatch: expected v%b h%b in %h out %h ax %0d/%b %0d/%b",
                     $time, want.result_valid, want.hit, want.enter_time, want.exit_time,
                     want.enter_axis, want.enter_negative, want.exit_axis,
                     want.exit_negative);
            $display("%0t          actual   v%b h%b in %h out %h ax %0d/%b %0d/%b",
                     $time, out_data_o.result_valid, out_data_o.hit, out_data_o.enter_time,
                     out_data_o.exit_time, out_data_o.enter_axis, out_data_o.enter_negative,
                     out_data_o.exit_axis, out_data_o.exit_negative);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic sbct_pkg::in_t box(int mx, int my, int mz, int sx, int sy, int sz,
                                        int tx, int ty, int tz, int vx, int vy, int vz);
    return '{mx, my, mz, sx[30:0], sy[30:0], sz[30:0], tx, ty, tz, vx, vy, vz};
  endfunction

  task automatic test_directed();
    int u = int'(Unit);
    int mn = 32'h80000000;
    int mx = 32'h7fffffff;
    // zero motion
    send_box(box(0, 0, 0, u, u, u, 0, 0, 0, 0, 0, 0));
    // plain hit along x, still y and z strictly overlapping
    send_box(box(0, 0, 0, u, u, u, 2*u, 0, 0, 4*u, 0, 0));
    // still axis only touching the target face
    send_box(box(0, 0, 0, u, u, u, 2*u, u, 0, 4*u, 0, 0));
    send_box(box(0, 0, 0, u, u, u, 2*u, -u, 0, 4*u, 0, 0));
    // negative motion, miss, entry on x
    send_box(box(5*u, 0, 0, u, u, u, 0, 3*u, 0, -u, -u, u));
    // equal times on all axes: first axis kept
    send_box(box(0, 0, 0, u, u, u, 2*u, 2*u, 2*u, u, u, u));
    send_box(box(0, 0, 0, u, u, u, 2*u, 2*u, 2*u, -u, -u, -u));
    // tiny motion saturates
    send_box(box(mn, 0, 0, 0, u, u, mx, 0, 0, 1, 0, 0));
    send_box(box(mx, 0, 0, mx, u, u, mn, 0, 0, -1, 0, 0));
    // extreme motion components
    send_box(box(0, 0, 0, u, u, u, u, u, u, mn, mx, mn));
    send_box(box(mn, mx, mn, mx, mx, mx, mx, mn, mx, mx, mn, 1));
    send_box(box(mx, mn, mx, 0, 0, 0, mn, mx, mn, -1, 1, -1));
    // zero-size moving box inside target, moving fast
    send_box(box(u/2, u/2, u/2, 0, 0, 0, 0, 0, 0, mx, mx, mx));
    // already overlapping, negative entry
    send_box(box(0, 0, 0, 2*u, 2*u, 2*u, u, u, u, u, -u, u/3));
  endtask

  task automatic test_extents();
    int u = int'(Unit);
    set_exts('0, 31'h7fffffff, '0);
    // zero-width target: a still axis overlaps strictly only if the target lies inside the moving box
    send_box(box(0, 0, 0, u, u, u, 0, 0, 0, 0, u, u));
    send_box(box(0, 0, 0, u, u, u, u/2, 0, 0, u, 0, u));
    send_box(box(32'h80000000, 0, 32'h80000000, 31'h7fffffff, u, 31'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 3, 0, -7));
    // the spare index must not disturb the extents
    drain();
    write_ext(sbct_pkg::CFG_UNUSED, 31'h12345);
    cfg_we_i <= 1'b0;
    send_box(box(0, 0, 0, u, u, u, u/2, 0, 0, u, 0, u));
  endtask

  task automatic test_random(logic [sbct_pkg::SizeW-1:0] sx, logic [sbct_pkg::SizeW-1:0] sy,
                             logic [sbct_pkg::SizeW-1:0] sz,
                             int unsigned s_pct, int unsigned r_pct);
    set_exts(sx, sy, sz);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (RandItems) send_box(rand_box());
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = sbct_pkg::CFG_TARGET_SIZE_X;
    cfg_wdata_i    = '0;
    failed         = 1'b0;
    cycles         = 0;
    send_idle_pct  = 15;
    recv_stall_pct = 51;
    for (int i = 0; i < sbct_pkg::NumAxes; i++) target_ext[i] = sbct_pkg::SizeW'(Unit);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_extents();
    test_random(sbct_pkg::SizeW'(Unit), sbct_pkg::SizeW'(Unit), sbct_pkg::SizeW'(Unit),
                15, 51);
    test_random(31'($urandom_range(8 * Unit)), 31'($urandom_range(8 * Unit)),
                31'($urandom_range(8 * Unit)), 51, 15);
    test_random(31'h7fffffff, 31'($urandom), 31'($urandom_range(2 * Unit)), 0, 0);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
